/* src/ckit_pkg.sv */
package ckit_pkg;

  // text field sizes
  localparam int NAME_BYTES = 29;
  localparam int KIND_BYTES = 19;
  localparam int NAME_BITS  = NAME_BYTES * 8;
  localparam int KIND_BITS  = KIND_BYTES * 8;

  // request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LIST   = 2'd2;
  localparam logic [1:0] MODE_SEARCH = 2'd3;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_FOUND    = 3'd5;
  localparam logic [2:0] ST_LISTED   = 3'd6;

  typedef logic [NAME_BITS-1:0] name_t;
  typedef logic [KIND_BITS-1:0] kind_t;

  typedef struct packed {
    name_t              name;
    kind_t              kind;
    logic signed [31:0] amount;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] status;
    logic [3:0] position;
    entry_t     entry;
    logic [3:0] held;
    logic       last;
  } res_t;

  // build one result word
  function automatic res_t make_res(input logic [2:0] status, input logic [3:0] position,
                                    input entry_t entry, input logic [3:0] held,
                                    input logic last);
    res_t r;
    r.valid    = 1'b1;
    r.status   = status;
    r.position = position;
    r.entry    = entry;
    r.held     = held;
    r.last     = last;
    return r;
  endfunction

endpackage

/* src/ckit_clean.sv */
module ckit_clean
  import ckit_pkg::*;
#(
  parameter int NBYTES = 29
) (
  input  logic [NBYTES*8-1:0] raw,
  output logic [NBYTES*8-1:0] text
);

  logic [NBYTES-1:0] zero;
  logic [NBYTES-1:0] below;

  // string semantics: every byte after the first zero byte reads as zero
  always_comb begin
    for (int b = 0; b < NBYTES; b++) begin
      zero[b] = (raw[b*8 +: 8] == 8'h00);
    end
    for (int b = 0; b < NBYTES; b++) begin
      below = (NBYTES'(1) << b) - NBYTES'(1);
      text[b*8 +: 8] = (|(zero & below)) ? 8'h00 : raw[b*8 +: 8];
    end
  end

endmodule

/* src/ckit_store.sv */
module ckit_store
  import ckit_pkg::*;
#(
  parameter int CAPACITY = 10,
  parameter int IW       = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [CAPACITY];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one read port, registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ckit_ctrl.sv */
module ckit_ctrl
  import ckit_pkg::*;
#(
  parameter int CAPACITY = 10,
  parameter int IW       = 4,
  parameter int CW       = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         mode,
  input  name_t              key,
  input  kind_t              kind,
  input  logic signed [31:0] amount,
  output logic               busy,
  output res_t               res,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output entry_t             mem_wdata,
  output logic               mem_re,
  output logic [IW-1:0]      mem_raddr,
  input  entry_t             mem_rdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_LIST  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [1:0]    state;
  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  logic          chk_valid;
  logic [IW-1:0] chk_idx;
  logic [IW-1:0] hit_idx;
  logic [1:0]    mode_q;
  name_t         key_q;
  res_t          res_q;

  logic          issue;
  logic          hit_now;
  logic          chk_last;
  logic          insert_now;
  logic          shift_wr;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] fill_dec;
  logic [CW+3:0] fill_x;
  logic [CW+3:0] fill_inc_x;
  logic [CW+3:0] fill_dec_x;
  logic [IW+3:0] chk_x;
  logic [IW+3:0] hit_x;
  entry_t        blank;
  entry_t        new_entry;

  // read issue and compare
  always_comb begin
    hit_now  = chk_valid && (mem_rdata.name == key_q);
    chk_last = (CW'(chk_idx) == fill - CW'(1));
    issue    = (idx < fill) &&
               ((state == S_LIST) || (state == S_SHIFT) || ((state == S_SCAN) && !hit_now));
  end

  // result field widths
  always_comb begin
    fill_inc   = fill + CW'(1);
    fill_dec   = fill - CW'(1);
    fill_x     = {4'b0, fill};
    fill_inc_x = {4'b0, fill_inc};
    fill_dec_x = {4'b0, fill_dec};
    chk_x      = {4'b0, chk_idx};
    hit_x      = {4'b0, hit_idx};
    blank      = '0;
    new_entry.name   = key;
    new_entry.kind   = kind;
    new_entry.amount = amount;
  end

  // memory port
  always_comb begin
    insert_now = (state == S_IDLE) && start && (mode == MODE_INSERT) && (fill != CAP);
    shift_wr   = (state == S_SHIFT) && chk_valid;
    mem_we     = insert_now || shift_wr;
    mem_waddr  = shift_wr ? (chk_idx - IW'(1)) : fill[IW-1:0];
    mem_wdata  = shift_wr ? mem_rdata : new_entry;
    mem_re     = issue;
    mem_raddr  = idx[IW-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      chk_valid <= 1'b0;
      res_q.valid <= 1'b0;
    end else begin
      res_q.valid <= 1'b0;
      chk_valid   <= issue;
      if (issue) begin
        chk_idx <= idx[IW-1:0];
        idx     <= idx + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key_q  <= key;
            mode_q <= mode;
            idx    <= '0;
            priority if (mode == MODE_INSERT) begin
              if (fill == CAP) begin
                res_q <= make_res(ST_FULL, 4'd0, blank, fill_x[3:0], 1'b1);
              end else begin
                fill  <= fill_inc;
                res_q <= make_res(ST_INSERTED, fill_x[3:0], blank, fill_inc_x[3:0], 1'b1);
              end
            end else if (fill == '0) begin
              res_q <= make_res(ST_EMPTY, 4'd0, blank, fill_x[3:0], 1'b1);
            end else if (mode == MODE_LIST) begin
              state <= S_LIST;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_LIST: begin
          if (chk_valid) begin
            res_q <= make_res(ST_LISTED, chk_x[3:0], mem_rdata, fill_x[3:0], chk_last);
            if (chk_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          // a hit holds off the next read, so no check is left in flight
          priority if (hit_now) begin
            if (mode_q == MODE_SEARCH) begin
              res_q <= make_res(ST_FOUND, chk_x[3:0], mem_rdata, fill_x[3:0], 1'b1);
              state <= S_IDLE;
            end else begin
              hit_idx <= chk_idx;
              idx     <= CW'(chk_idx) + CW'(1);
              state   <= S_SHIFT;
            end
          end else if (chk_valid && chk_last) begin
            res_q <= make_res(ST_NOTFOUND, 4'd0, blank, fill_x[3:0], 1'b1);
            state <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SHIFT: begin
          if (!chk_valid && !issue) begin
            fill  <= fill_dec;
            res_q <= make_res(ST_REMOVED, hit_x[3:0], blank, fill_dec_x[3:0], 1'b1);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign res  = res_q;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= CAP)
    else $error("fill count above capacity");

  a_busy_ends_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> res_q.valid && res_q.last)
    else $error("request ended without a last result");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    res_q.valid && !res_q.last |-> busy)
    else $error("non-last result while idle");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write of the same entry in one cycle");

endmodule

/* src/compacting_keyed_item_table.sv */
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+-------------------------------
// request   | mode, key_word0-3, kind_word0-2, amount_in   | start, taken when busy is low
// result    | status, position, out_*, amount_out,         | result_valid, one cycle each
//           | entries_held, last                           |
//
// insert and any request on an empty table: one result, the cycle after the request
// search and remove scan the table memory one entry per cycle until a hit or the last entry
// remove then moves the later entries down, one read and one write per cycle
// list: one result per entry on consecutive cycles, once the first entry read is back
// synchronous reset empties the table; entry memory itself is not cleared
// the receiver cannot stall; every result must be taken in its cycle
module compacting_keyed_item_table
  import ckit_pkg::*;
#(
  parameter int CAPACITY = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [63:0]        key_word0,
  input  logic [63:0]        key_word1,
  input  logic [63:0]        key_word2,
  input  logic [39:0]        key_word3,
  input  logic [63:0]        kind_word0,
  input  logic [63:0]        kind_word1,
  input  logic [23:0]        kind_word2,
  input  logic signed [31:0] amount_in,
  output logic               result_valid,
  output logic [2:0]         status,
  output logic [3:0]         position,
  output logic [63:0]        out_key_word0,
  output logic [63:0]        out_key_word1,
  output logic [63:0]        out_key_word2,
  output logic [39:0]        out_key_word3,
  output logic [63:0]        out_kind_word0,
  output logic [63:0]        out_kind_word1,
  output logic [23:0]        out_kind_word2,
  output logic signed [31:0] amount_out,
  output logic [3:0]         entries_held,
  output logic               last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  name_t         key_clean;
  kind_t         kind_clean;
  res_t          res;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // text cleanup of the request key and type
  ckit_clean #(.NBYTES(NAME_BYTES)) u_name_clean (
    .raw  ({key_word3, key_word2, key_word1, key_word0}),
    .text (key_clean)
  );

  ckit_clean #(.NBYTES(KIND_BYTES)) u_kind_clean (
    .raw  ({kind_word2, kind_word1, kind_word0}),
    .text (kind_clean)
  );

  // sequencer
  ckit_ctrl #(.CAPACITY(CAPACITY), .IW(IW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .key       (key_clean),
    .kind      (kind_clean),
    .amount    (amount_in),
    .busy      (busy),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // entry memory
  ckit_store #(.CAPACITY(CAPACITY), .IW(IW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result ports
  assign result_valid   = res.valid;
  assign status         = res.status;
  assign position       = res.position;
  assign out_key_word0  = res.entry.name[63:0];
  assign out_key_word1  = res.entry.name[127:64];
  assign out_key_word2  = res.entry.name[191:128];
  assign out_key_word3  = res.entry.name[231:192];
  assign out_kind_word0 = res.entry.kind[63:0];
  assign out_kind_word1 = res.entry.kind[127:64];
  assign out_kind_word2 = res.entry.kind[151:128];
  assign amount_out     = res.entry.amount;
  assign entries_held   = res.held;
  assign last           = res.last;

endmodule
